### hw/rtl/ocvm_pkg.sv
// Shared types, constants and arithmetic helpers of the orbit camera view block.
`default_nettype none

package ocvm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int CFG_W          = 32;

    localparam logic [30:0] DIST_RESET   = 31'd327680;
    localparam logic [31:0] HEIGHT_RESET = 32'd131072;
    localparam logic [30:0] ONE30        = 31'h4000_0000;
    localparam logic [31:0] POLY_SEED    = 32'd3864;

    typedef enum logic {
        REG_DISTANCE = 1'b0,
        REG_HEIGHT   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [30:0]        distance;
        logic signed [31:0] height;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        phase;
    } item_t;

    typedef logic signed [67:0] wide_t;

    // Odd sine polynomial coefficients, Q30, applied highest order first.
    function automatic logic [31:0] poly_coef(input logic [2:0] k);
        logic [31:0] c;
        case (k)
            3'd1:    c = 32'd172272;
            3'd2:    c = 32'd5026989;
            3'd3:    c = 32'd85569306;
            3'd4:    c = 32'd693598668;
            3'd5:    c = 32'd1686629713;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

    // Shift right with rounding half away from zero.
    function automatic wide_t round_shift(input wide_t v, input int unsigned sh);
        wide_t mag;
        wide_t r;
        mag = v[67] ? -v : v;
        r   = (mag + (wide_t'(1) << (sh - 1))) >>> sh;
        return v[67] ? -r : r;
    endfunction

    function automatic logic [31:0] sat32(input wide_t v);
        logic [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -68'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ocvm_front.sv
// Front end: accept frame words, update the kept yaw angle, form the phase.
`default_nettype none

module ocvm_front #(
    parameter int ANGLE_BITS = ocvm_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [31:0]  object_x,
    input  wire logic signed [31:0]  object_y,
    input  wire logic signed [31:0]  object_z,
    input  wire logic [15:0]         yaw_value,
    input  wire logic                yaw_load,
    input  wire logic                q_full,
    output logic                     q_push,
    output ocvm_pkg::item_t          q_data
);
    import ocvm_pkg::*;

    logic [ANGLE_BITS-1:0] angle_reg;
    logic [ANGLE_BITS-1:0] angle_next;
    logic [39:0]           step_wide;
    logic [ANGLE_BITS-1:0] step;

    assign in_ready  = !q_full;
    assign q_push    = in_valid && in_ready;
    assign step_wide = {yaw_value, 24'd0} >> (40 - ANGLE_BITS);
    assign step      = step_wide[ANGLE_BITS-1:0];

    always_comb
    begin
        if (yaw_load)
            angle_next = step;
        else
            angle_next = angle_reg + step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angle_reg <= '0;
        else if (q_push)
            angle_reg <= angle_next;
    end

    assign q_data.x     = object_x;
    assign q_data.y     = object_y;
    assign q_data.z     = object_z;
    assign q_data.phase = {angle_next, {(32 - ANGLE_BITS){1'b0}}};

endmodule

`default_nettype wire

### hw/rtl/ocvm_queue.sv
// Two-entry queue between front and back end.
`default_nettype none

module ocvm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  ocvm_pkg::item_t      push_data,
    output logic                 full,
    input  wire logic            pop,
    output ocvm_pkg::item_t      pop_data,
    output logic                 empty
);
    import ocvm_pkg::*;

    item_t       mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ocvm_back.sv
// Back end: sequencer with one shared multiplier, root and divide units.
`default_nettype none

module ocvm_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  ocvm_pkg::cfg_t          cfg,
    input  wire logic               q_empty,
    input  ocvm_pkg::item_t         q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      right_x,
    output logic signed [15:0]      right_y,
    output logic signed [15:0]      right_z,
    output logic signed [15:0]      up_x,
    output logic signed [15:0]      up_y,
    output logic signed [15:0]      up_z,
    output logic signed [15:0]      back_x,
    output logic signed [15:0]      back_y,
    output logic signed [15:0]      back_z,
    output logic signed [31:0]      shift_right,
    output logic signed [31:0]      shift_up,
    output logic signed [31:0]      shift_back
);
    import ocvm_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MUL      = 8'b0000_0010,
        ST_USE      = 8'b0000_0100,
        ST_NORM     = 8'b0000_1000,
        ST_SQRT     = 8'b0001_0000,
        ST_DIV_INIT = 8'b0010_0000,
        ST_DIV      = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    localparam logic [4:0] OP_POLY_FIRST = 5'd0;
    localparam logic [4:0] OP_HI_FIRST   = 5'd7;
    localparam logic [4:0] OP_POLY_LAST  = 5'd13;
    localparam logic [4:0] OP_DX         = 5'd14;
    localparam logic [4:0] OP_DZ         = 5'd15;
    localparam logic [4:0] OP_SQ_D       = 5'd16;
    localparam logic [4:0] OP_SQ_H       = 5'd17;
    localparam logic [4:0] OP_R3         = 5'd18;
    localparam logic [4:0] OP_R5         = 5'd19;
    localparam logic [4:0] OP_R6         = 5'd20;
    localparam logic [4:0] OP_R8         = 5'd21;
    localparam logic [4:0] OP_D0A        = 5'd22;
    localparam logic [4:0] OP_D0B        = 5'd23;
    localparam logic [4:0] OP_D1A        = 5'd24;
    localparam logic [4:0] OP_D1B        = 5'd25;
    localparam logic [4:0] OP_D1C        = 5'd26;
    localparam logic [4:0] OP_D2A        = 5'd27;
    localparam logic [4:0] OP_D2B        = 5'd28;
    localparam logic [4:0] OP_D2C        = 5'd29;

    state_t state_reg, state_next;
    logic [4:0] op_reg, op_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    item_t              item_reg;
    logic [30:0]        x2_reg;
    logic [31:0]        t_reg;
    logic [30:0]        slo_reg, shi_reg;
    logic signed [33:0] dx_reg, dz_reg;
    logic [30:0]        ddn_reg;
    logic [31:0]        hmn_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        r_reg;
    logic [31:0]        remp_reg, remh_reg;
    logic [30:0]        qp_reg, qh_reg;
    logic signed [31:0] pn_reg, hn_reg;
    logic signed [15:0] row3_reg, row5_reg, row6_reg, row8_reg;
    logic signed [67:0] prod_reg;
    logic signed [51:0] dot_reg [3];

    logic [29:0]        frac;
    logic [1:0]         quad;
    logic [30:0]        x_arg;
    logic [2:0]         k;
    logic signed [31:0] sn, cs;
    logic signed [33:0] ex, ey, ez;
    logic signed [15:0] row0, row2, row4, row7;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic [31:0]        poly_top;
    logic [30:0]        poly_clamped;
    logic [63:0]        sq_bit, sq_try;
    logic [31:0]        len;
    logic [62:0]        nump, numh;
    logic [32:0]        tp, th;
    logic               bp, bh;
    logic [30:0]        qp_new, qh_new;
    logic [30:0]        norm_max;
    logic [31:0]        hmag;

    assign frac  = item_reg.phase[29:0];
    assign quad  = item_reg.phase[31:30];
    assign x_arg = (op_reg >= OP_HI_FIRST) ? (ONE30 - {1'b0, frac}) : {1'b0, frac};
    assign k     = (op_reg >= OP_HI_FIRST) ? 3'(op_reg - OP_HI_FIRST) : op_reg[2:0];
    assign hmag  = cfg.height[31] ? 32'(-cfg.height) : cfg.height;

    // Fold the quarter-wave values back to the full circle.
    always_comb
    begin
        case (quad)
            2'd0:    begin sn =  32'(slo_reg); cs =  32'(shi_reg); end
            2'd1:    begin sn =  32'(shi_reg); cs = -32'(slo_reg); end
            2'd2:    begin sn = -32'(slo_reg); cs = -32'(shi_reg); end
            default: begin sn = -32'(shi_reg); cs =  32'(slo_reg); end
        endcase
    end

    assign ex = 34'(item_reg.x) + dx_reg;
    assign ey = 34'(item_reg.y) + 34'(cfg.height);
    assign ez = 34'(item_reg.z) + dz_reg;

    assign row0 = 16'(round_shift(68'(cs), 16));
    assign row2 = 16'(round_shift(-68'(sn), 16));
    assign row4 = 16'(round_shift(68'(pn_reg), 16));
    assign row7 = 16'(round_shift(68'(hn_reg), 16));

    // Operand select of the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg) inside
            [OP_POLY_FIRST:OP_POLY_LAST]:
            begin
                if (k == 3'd0)
                begin
                    mul_a = {3'b0, x_arg};
                    mul_b = {3'b0, x_arg};
                end
                else if (k == 3'd6)
                begin
                    mul_a = {3'b0, x_arg};
                    mul_b = {2'b0, t_reg};
                end
                else
                begin
                    mul_a = {3'b0, x2_reg};
                    mul_b = {2'b0, t_reg};
                end
            end
            OP_DX:   begin mul_a = {3'b0, cfg.distance}; mul_b = 34'(sn); end
            OP_DZ:   begin mul_a = {3'b0, cfg.distance}; mul_b = 34'(cs); end
            OP_SQ_D: begin mul_a = {3'b0, ddn_reg};      mul_b = {3'b0, ddn_reg}; end
            OP_SQ_H: begin mul_a = {2'b0, hmn_reg};      mul_b = {2'b0, hmn_reg}; end
            OP_R3:   begin mul_a = -34'(sn);  mul_b = 34'(hn_reg); end
            OP_R5:   begin mul_a = -34'(cs);  mul_b = 34'(hn_reg); end
            OP_R6:   begin mul_a = 34'(sn);   mul_b = 34'(pn_reg); end
            OP_R8:   begin mul_a = 34'(cs);   mul_b = 34'(pn_reg); end
            OP_D0A:  begin mul_a = 34'(row0); mul_b = ex; end
            OP_D0B:  begin mul_a = 34'(row2); mul_b = ez; end
            OP_D1A:  begin mul_a = 34'(row3_reg); mul_b = ex; end
            OP_D1B:  begin mul_a = 34'(row4); mul_b = ey; end
            OP_D1C:  begin mul_a = 34'(row5_reg); mul_b = ez; end
            OP_D2A:  begin mul_a = 34'(row6_reg); mul_b = ex; end
            OP_D2B:  begin mul_a = 34'(row7); mul_b = ey; end
            OP_D2C:  begin mul_a = 34'(row8_reg); mul_b = ez; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod         = mul_a * mul_b;
    assign poly_top     = prod_reg[61:30];
    assign poly_clamped = (poly_top > {1'b0, ONE30}) ? ONE30 : poly_top[30:0];

    assign norm_max = ({1'b0, ddn_reg} > hmn_reg) ? ddn_reg : hmn_reg[30:0];

    assign sq_bit = 64'd1 << {cnt_reg, 1'b0};
    assign sq_try = r_reg + sq_bit;

    // Dividends are the normalized values in Q30 plus half the divisor.
    assign len  = r_reg[31:0];
    assign nump = {2'b0, ddn_reg, 30'd0} + 63'(len >> 1);
    assign numh = {1'b0, hmn_reg, 30'd0} + 63'(len >> 1);

    assign tp     = {remp_reg, qp_reg[30]};
    assign th     = {remh_reg, qh_reg[30]};
    assign bp     = (tp >= {1'b0, len});
    assign bh     = (th >= {1'b0, len});
    assign qp_new = {qp_reg[29:0], bp};
    assign qh_new = {qh_reg[29:0], bh};

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;

    // Control sequencing.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    op_next    = OP_POLY_FIRST;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_USE;
            ST_USE:
            begin
                op_next = op_reg + 5'd1;
                if (op_reg == OP_DZ)
                    state_next = ST_NORM;
                else if (op_reg == OP_SQ_H)
                begin
                    cnt_next   = 5'd31;
                    state_next = ST_SQRT;
                end
                else if (op_reg == OP_D2C)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            end
            ST_NORM:
            begin
                if (ddn_reg == '0 && hmn_reg == '0)
                begin
                    op_next    = OP_R3;
                    state_next = ST_MUL;
                end
                else if (ddn_reg[30] || hmn_reg[31] || hmn_reg[30])
                    state_next = ST_MUL;
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cnt_next   = 5'd30;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    op_next    = OP_R3;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    item_reg <= q_data;
                    t_reg    <= POLY_SEED;
                    ddn_reg  <= cfg.distance;
                    hmn_reg  <= hmag;
                end
            end
            ST_MUL:
                prod_reg <= prod;
            ST_USE:
            begin
                case (op_reg) inside
                    [OP_POLY_FIRST:OP_POLY_LAST]:
                    begin
                        if (k == 3'd0)
                            x2_reg <= prod_reg[60:30];
                        else if (k == 3'd6)
                        begin
                            t_reg <= POLY_SEED;
                            if (op_reg == OP_POLY_LAST)
                                shi_reg <= poly_clamped;
                            else
                                slo_reg <= poly_clamped;
                        end
                        else
                            t_reg <= poly_coef(k) - poly_top;
                    end
                    OP_DX:   dx_reg <= 34'(round_shift(prod_reg, 30));
                    OP_DZ:   dz_reg <= 34'(round_shift(prod_reg, 30));
                    OP_SQ_D: sum_reg <= prod_reg[63:0];
                    OP_SQ_H:
                    begin
                        sum_reg <= sum_reg + prod_reg[63:0];
                        r_reg   <= '0;
                    end
                    OP_R3:   row3_reg <= 16'(round_shift(prod_reg, 46));
                    OP_R5:   row5_reg <= 16'(round_shift(prod_reg, 46));
                    OP_R6:   row6_reg <= 16'(round_shift(prod_reg, 46));
                    OP_R8:   row8_reg <= 16'(round_shift(prod_reg, 46));
                    OP_D0A:  dot_reg[0] <= prod_reg[51:0];
                    OP_D0B:  dot_reg[0] <= dot_reg[0] + prod_reg[51:0];
                    OP_D1A:  dot_reg[1] <= prod_reg[51:0];
                    OP_D1B, OP_D1C: dot_reg[1] <= dot_reg[1] + prod_reg[51:0];
                    OP_D2A:  dot_reg[2] <= prod_reg[51:0];
                    OP_D2B, OP_D2C: dot_reg[2] <= dot_reg[2] + prod_reg[51:0];
                    default: ;
                endcase
            end
            ST_NORM:
            begin
                if (ddn_reg == '0 && hmn_reg == '0)
                begin
                    pn_reg <= 32'({1'b0, ONE30});
                    hn_reg <= '0;
                end
                else if (!(ddn_reg[30] || hmn_reg[31] || hmn_reg[30]))
                begin
                    // Coarse step while far below the target, then single bits.
                    if (norm_max < 31'h0040_0000)
                    begin
                        ddn_reg <= ddn_reg << 8;
                        hmn_reg <= hmn_reg << 8;
                    end
                    else
                    begin
                        ddn_reg <= ddn_reg << 1;
                        hmn_reg <= hmn_reg << 1;
                    end
                end
            end
            ST_SQRT:
            begin
                if (sum_reg >= sq_try)
                begin
                    sum_reg <= sum_reg - sq_try;
                    r_reg   <= (r_reg >> 1) + sq_bit;
                end
                else
                    r_reg <= r_reg >> 1;
            end
            ST_DIV_INIT:
            begin
                remp_reg <= nump[62:31];
                qp_reg   <= nump[30:0];
                remh_reg <= numh[62:31];
                qh_reg   <= numh[30:0];
            end
            ST_DIV:
            begin
                remp_reg <= bp ? 32'(tp - {1'b0, len}) : tp[31:0];
                remh_reg <= bh ? 32'(th - {1'b0, len}) : th[31:0];
                qp_reg   <= qp_new;
                qh_reg   <= qh_new;
                if (cnt_reg == 5'd0)
                begin
                    pn_reg <= 32'(qp_new);
                    hn_reg <= cfg.height[31] ? -32'(qh_new) : 32'(qh_new);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    right_x     <= row0;
                    right_y     <= '0;
                    right_z     <= row2;
                    up_x        <= row3_reg;
                    up_y        <= row4;
                    up_z        <= row5_reg;
                    back_x      <= row6_reg;
                    back_y      <= row7;
                    back_z      <= row8_reg;
                    shift_right <= sat32(-round_shift(68'(dot_reg[0]), 14));
                    shift_up    <= sat32(-round_shift(68'(dot_reg[1]), 14));
                    shift_back  <= sat32(-round_shift(68'(dot_reg[2]), 14));
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/orbit_camera_view_matrix.sv
// Top level of the orbit camera look-at view matrix block.
`default_nettype none

// Orbit camera view matrix. Each input word carries an object position and a
// yaw step; the yaw is loaded or accumulated (wrapping once per turn) as the
// word is accepted, and the word waits in a two-entry queue for the back end.
// The back end takes one word at a time and pops the next only when idle;
// its work is set by its single shared 34x34 multiplier (about 30 products
// for sine, cosine, eye offset, squares, rows and dot products), the bit-pair
// square root and the bit-serial divide, plus the normalizing of distance
// and height. The finished result sits in an output register, so the front
// keeps taking words while the result waits, until the queue is full.
// Write camera_distance (index 0) and camera_height (index 1) through
// cfg_we/cfg_index/cfg_data only while idle.
module orbit_camera_view_matrix #(
    parameter int ANGLE_BITS = ocvm_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [ocvm_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [31:0]          object_x,
    input  wire logic signed [31:0]          object_y,
    input  wire logic signed [31:0]          object_z,
    input  wire logic [15:0]                 yaw_value,
    input  wire logic                        yaw_load,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [15:0]               right_x,
    output logic signed [15:0]               right_y,
    output logic signed [15:0]               right_z,
    output logic signed [15:0]               up_x,
    output logic signed [15:0]               up_y,
    output logic signed [15:0]               up_z,
    output logic signed [15:0]               back_x,
    output logic signed [15:0]               back_y,
    output logic signed [15:0]               back_z,
    output logic signed [31:0]               shift_right,
    output logic signed [31:0]               shift_up,
    output logic signed [31:0]               shift_back
);
    import ocvm_pkg::*;

    cfg_t  cfg_reg;
    logic  q_full, q_empty, q_push, q_pop;
    item_t q_in, q_out;

    // Hold orbit setup; user must land writes only between frames, unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distance <= DIST_RESET;
            cfg_reg.height   <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DISTANCE: cfg_reg.distance <= cfg_data[30:0];
                REG_HEIGHT:   cfg_reg.height   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Accept words and advance the yaw.
    ocvm_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .object_x  (object_x),
        .object_y  (object_y),
        .object_z  (object_z),
        .yaw_value (yaw_value),
        .yaw_load  (yaw_load),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // Decouple front and back so each can stall alone.
    ocvm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // Compute rows and translation terms, one word at a time.
    ocvm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .right_x     (right_x),
        .right_y     (right_y),
        .right_z     (right_z),
        .up_x        (up_x),
        .up_y        (up_y),
        .up_z        (up_z),
        .back_x      (back_x),
        .back_y      (back_y),
        .back_z      (back_z),
        .shift_right (shift_right),
        .shift_up    (shift_up),
        .shift_back  (shift_back)
    );

endmodule

`default_nettype wire

### hw/rtl/ocvm_checker.sv
// Port-level checks of the orbit camera block, bound to the top level.
`default_nettype none

module ocvm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] right_x,
    input wire logic signed [15:0] right_y,
    input wire logic signed [15:0] up_y
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(right_x))
        else $error("result word dropped or changed while stalled");

    a_right_flat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> right_y == 16'sd0)
        else $error("right row has a vertical part");

    a_up_upright: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !up_y[15])
        else $error("up row points down");

    a_right_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> right_x <= 16'sd16384 && right_x >= -16'sd16384)
        else $error("right row beyond unit length");

endmodule

bind orbit_camera_view_matrix ocvm_checker u_ocvm_checker (.*);

`default_nettype wire
